// ===== rtl/core/dedup_tile_slot_pool_top_assert.svh =====
// assertion macros for the slot pool checker
// expects clk and arst_n in the scope of the use
`ifndef DEDUP_TILE_SLOT_POOL_TOP_ASSERT_SVH
`define DEDUP_TILE_SLOT_POOL_TOP_ASSERT_SVH
// same-cycle implication
`define DTSP_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("%m: check failed");
// next-cycle implication
`define DTSP_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("%m: check failed");
`endif

// ===== rtl/core/dtsp_pkg.sv =====
// shared types, codes and the bucket hash of the tile slot pool
// no dependencies
`default_nettype none
package dtsp_pkg;
	localparam int DEF_SLOT_COUNT   = 512;
	localparam int DEF_BUCKET_COUNT = 256;
	localparam int DEF_MAX_LAYERS   = 3;
	localparam int ENTRY_W     = 16;
	localparam int REF_W       = 16;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] TILE_MASK = 16'h03FF;
	localparam logic [15:0] REF_MAX   = 16'hFFFF;
	localparam logic [9:0]  HASH_MUL  = 10'd33;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RECLAIM = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		OUT_NEW       = 3'd0,
		OUT_SHARED    = 3'd1,
		OUT_BLANK     = 3'd2,
		OUT_EXHAUSTED = 3'd3,
		OUT_RELEASED  = 3'd4,
		OUT_IGNORED   = 3'd5,
		OUT_RECLAIMED = 3'd6
	} outcome_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE,
		ST_ACQ_HEAD, ST_ACQ_HD, ST_ACQ_RD, ST_ACQ_CHK, ST_ACQ_MISS, ST_ACQ_POP,
		ST_REL_RD, ST_REL_CHK, ST_REL_HEAD, ST_REL_HD, ST_REL_WRD, ST_REL_WCHK,
		ST_REL_CLR, ST_RCL
	} st_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic [2:0]  n;
		logic [63:0] rec;
		logic [9:0]  bucket;
		logic [9:0]  slot;
		logic        slot_ok;
	} cmd_t;

	typedef struct packed {
		logic [8:0] slot_index;
		outcome_t   outcome;
		logic       needs_compose;
	} res_t;

	// h = n, then h = h*33 + entry; only the low ten bits can reach a bucket
	function automatic logic [9:0] dtsp_hash(input logic [63:0] rec, input logic [2:0] n);
		logic [9:0] h;
		h = 10'(n);
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < n) begin
				h = 10'(h * HASH_MUL) + rec[16*i +: 10];
			end
		end
		return h;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/dtsp_front.sv =====
// front part: accepts requests, compacts the recipe and hashes it
// depends on dtsp_pkg
`default_nettype none
module dtsp_front import dtsp_pkg::*; #(
	parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
	parameter int MAX_LAYERS   = DEF_MAX_LAYERS
) (
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  clearing,
	input  wire logic                  q_full,
	output logic                       q_push,
	output cmd_t                       cmd
);
	logic [63:0] norm;
	logic [2:0]  n;
	logic [9:0]  h;
	logic [15:0] rel;

	assign s_tready = !q_full && !clearing;
	assign q_push   = s_tvalid && s_tready;
	assign rel      = s_tdata[82:67];

	always_comb begin
		logic [2:0]  cnt;
		logic [15:0] e;
		cnt  = (s_tdata[2:0] > 3'd4) ? 3'd4 : s_tdata[2:0];
		norm = '0;
		n    = '0;
		for (int i = 0; i < 4; i++) begin
			e = s_tdata[3 + 16*i +: 16];
			if (3'(i) < cnt && (e & TILE_MASK) != 16'd0 && n < 3'(MAX_LAYERS)) begin
				norm[16*n +: 16] = e;
				n = n + 3'd1;
			end
		end
	end

	assign h = dtsp_hash(norm, n);

	always_comb begin
		cmd.op      = op_t'(s_tuser);
		cmd.n       = n;
		cmd.rec     = norm;
		cmd.bucket  = h & 10'(BUCKET_COUNT - 1);
		cmd.slot    = rel[9:0];
		cmd.slot_ok = (rel != 16'd0) && (rel < 16'(SLOT_COUNT));
	end
endmodule
`default_nettype wire

// ===== rtl/core/dtsp_queue.sv =====
// two-entry queue of classified requests between front and back
// depends on dtsp_pkg
`default_nettype none
module dtsp_queue import dtsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);
	localparam int AW = $clog2(QUEUE_DEPTH);

	cmd_t          ent_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + AW'(1);
			if (pop)  rp_q <= rp_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/dtsp_back.sv =====
// back part: sequencer over slot, bucket head, free and pending memories
// depends on dtsp_pkg
`default_nettype none
module dtsp_back import dtsp_pkg::*; #(
	parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
	parameter int MAX_LAYERS   = DEF_MAX_LAYERS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t q_data,
	input  wire logic q_empty,
	output logic      q_pop,
	input  wire logic pool_en,
	output logic      clearing,
	output res_t      res,
	output logic      res_valid,
	input  wire logic res_ready
);
	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int LW    = SW + 1;
	localparam int DW    = SW + 1;
	localparam int BW    = $clog2(BUCKET_COUNT);
	localparam int RW    = MAX_LAYERS * ENTRY_W;
	localparam int EW    = RW + REF_W + LW;
	localparam int CLR_N = (SLOT_COUNT > BUCKET_COUNT) ? SLOT_COUNT : BUCKET_COUNT;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [LW-1:0] SENT     = {LW{1'b1}};
	localparam logic [BW-1:0] BKT_MASK = BW'(BUCKET_COUNT - 1);

	// slot entry: recipe, refcount, next link from the top bit down
	logic [EW-1:0] slot_mem [SLOT_COUNT];
	logic [LW-1:0] head_mem [BUCKET_COUNT];
	logic [SW-1:0] free_mem [SLOT_COUNT];
	logic [SW-1:0] pend_mem [SLOT_COUNT];

	logic          slot_we;
	logic [SW-1:0] slot_wa, slot_ra;
	logic [EW-1:0] slot_wd, slot_rdata;
	logic          head_we;
	logic [BW-1:0] head_wa, head_ra;
	logic [LW-1:0] head_wd, head_rdata;
	logic          free_we;
	logic [SW-1:0] free_wa, free_ra, free_wd, free_rdata;
	logic          pend_we;
	logic [SW-1:0] pend_wa, pend_ra, pend_wd, pend_rdata;

	st_t           st_q, st_d;
	cmd_t          cmd_q;
	logic [LW-1:0] cur_q, prev_q, headv_q, snext_q;
	logic [EW-1:0] prev_ent_q;
	logic [DW-1:0] steps_q, fd_q, pd_q;
	logic [BW-1:0] bkt_q;
	logic [CW-1:0] clr_q;
	res_t          res_q, out_q;
	logic          out_valid_q;
	logic          rcl_wr_q;

	logic [LW-1:0]    rd_next;
	logic [REF_W-1:0] rd_ref, ref_sat_inc;
	logic [RW-1:0]    rd_rec, cmd_rec;
	logic [BW-1:0]    cmd_bkt, rel_bkt;
	logic [SW-1:0]    s_idx;
	logic [DW-1:0]    steps_inc, fd_dec, pd_dec;
	logic [2:0]       rel_n;
	logic [9:0]       rel_h;
	logic             match, next_ok, pop_ok, clr_slot, clr_bkt, clr_last, out_load;

	assign rd_next     = slot_rdata[LW-1:0];
	assign rd_ref      = slot_rdata[LW+REF_W-1:LW];
	assign rd_rec      = slot_rdata[EW-1:LW+REF_W];
	assign cmd_rec     = cmd_q.rec[RW-1:0];
	assign cmd_bkt     = cmd_q.bucket[BW-1:0];
	assign s_idx       = cmd_q.slot[SW-1:0];
	assign steps_inc   = steps_q + DW'(1);
	assign fd_dec      = fd_q - DW'(1);
	assign pd_dec      = pd_q - DW'(1);
	assign ref_sat_inc = (rd_ref == REF_MAX) ? rd_ref : rd_ref + REF_W'(1);
	assign match       = (rd_rec == cmd_rec);
	assign next_ok     = (rd_next < LW'(SLOT_COUNT)) && (steps_inc < DW'(SLOT_COUNT));
	assign pop_ok      = ({1'b0, free_rdata} < DW'(SLOT_COUNT));
	assign clr_slot    = ({1'b0, clr_q} < (CW+1)'(SLOT_COUNT));
	assign clr_bkt     = ({1'b0, clr_q} < (CW+1)'(BUCKET_COUNT));
	assign clr_last    = (clr_q == CW'(CLR_N - 1));
	assign out_load    = (st_q == ST_IDLE) ? 1'b0 : 1'b0;

	// recipe length of the slot being released, then its bucket
	always_comb begin
		logic stop;
		stop  = 1'b0;
		rel_n = '0;
		for (int i = 0; i < MAX_LAYERS; i++) begin
			if (!stop && rd_rec[16*i +: 16] != 16'd0) rel_n = rel_n + 3'd1;
			else stop = 1'b1;
		end
	end
	assign rel_h   = dtsp_hash(64'(rd_rec), rel_n);
	assign rel_bkt = rel_h[BW-1:0] & BKT_MASK;

	// result hold: a finished result waits here until the output register is free
	logic done_q, done_take;
	assign done_take = done_q && (!out_valid_q || res_ready);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR:    if (clr_last) st_d = ST_IDLE;
			ST_IDLE: begin
				if (!q_empty && !done_q) begin
					case (q_data.op)
						OP_ACQUIRE: st_d = (q_data.n == 3'd0) ? ST_IDLE : ST_ACQ_HEAD;
						OP_RELEASE: st_d = q_data.slot_ok ? ST_REL_RD : ST_IDLE;
						OP_RECLAIM: st_d = pool_en ? ST_RCL : ST_IDLE;
						default:    st_d = ST_IDLE;
					endcase
				end
			end
			ST_ACQ_HEAD: st_d = ST_ACQ_HD;
			ST_ACQ_HD:   st_d = (head_rdata < LW'(SLOT_COUNT)) ? ST_ACQ_RD : ST_ACQ_MISS;
			ST_ACQ_RD:   st_d = ST_ACQ_CHK;
			ST_ACQ_CHK: begin
				if (match) st_d = ST_IDLE;
				else st_d = next_ok ? ST_ACQ_RD : ST_ACQ_MISS;
			end
			ST_ACQ_MISS: st_d = (fd_q == '0) ? ST_IDLE : ST_ACQ_POP;
			ST_ACQ_POP:  st_d = ST_IDLE;
			ST_REL_RD:   st_d = ST_REL_CHK;
			ST_REL_CHK:  st_d = (rd_ref == REF_W'(1)) ? ST_REL_HEAD : ST_IDLE;
			ST_REL_HEAD: st_d = ST_REL_HD;
			ST_REL_HD:   st_d = (head_rdata < LW'(SLOT_COUNT)) ? ST_REL_WRD : ST_REL_CLR;
			ST_REL_WRD:  st_d = (cur_q == LW'(s_idx)) ? ST_REL_CLR : ST_REL_WCHK;
			ST_REL_WCHK: st_d = next_ok ? ST_REL_WRD : ST_REL_CLR;
			ST_REL_CLR:  st_d = ST_IDLE;
			ST_RCL:      st_d = (pd_q == '0) ? ST_IDLE : ST_RCL;
			default:     st_d = ST_IDLE;
		endcase
	end

	// leaving a work state for idle, or a request popped that stays in idle, finishes the item
	logic finish;
	assign finish = (st_q != ST_IDLE) && (st_q != ST_CLEAR) && (st_d == ST_IDLE)
		|| (st_q == ST_IDLE && st_d == ST_IDLE && q_pop);

	always_comb begin
		q_pop   = (st_q == ST_IDLE) && !q_empty && !done_q;
		slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;
		head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
		free_we = 1'b0; free_wa = '0; free_wd = '0; free_ra = '0;
		pend_we = 1'b0; pend_wa = '0; pend_wd = '0; pend_ra = '0;
		case (st_q)
			ST_CLEAR: begin
				slot_we = clr_slot;
				slot_wa = SW'(clr_q);
				slot_wd = {{(RW+REF_W){1'b0}}, SENT};
				head_we = clr_bkt;
				head_wa = BW'(clr_q);
				head_wd = SENT;
				free_we = clr_slot;
				free_wa = SW'(clr_q);
				free_wd = SW'(SLOT_COUNT - 1) - SW'(clr_q);
			end
			ST_ACQ_HEAD: head_ra = cmd_bkt;
			ST_ACQ_RD:   slot_ra = cur_q[SW-1:0];
			ST_ACQ_CHK: begin
				slot_we = match;
				slot_wa = cur_q[SW-1:0];
				slot_wd = {rd_rec, ref_sat_inc, rd_next};
			end
			ST_ACQ_MISS: free_ra = fd_dec[SW-1:0];
			ST_ACQ_POP: begin
				slot_we = pop_ok;
				slot_wa = free_rdata;
				slot_wd = {cmd_rec, REF_W'(1), headv_q};
				head_we = pop_ok;
				head_wa = cmd_bkt;
				head_wd = LW'(free_rdata);
			end
			ST_REL_RD: slot_ra = s_idx;
			ST_REL_CHK: begin
				slot_we = (rd_ref > REF_W'(1));
				slot_wa = s_idx;
				slot_wd = {rd_rec, rd_ref - REF_W'(1), rd_next};
			end
			ST_REL_HEAD: head_ra = bkt_q;
			ST_REL_WRD: begin
				if (cur_q == LW'(s_idx)) begin
					if (prev_q == SENT) begin
						head_we = 1'b1;
						head_wa = bkt_q;
						head_wd = snext_q;
					end else begin
						slot_we = 1'b1;
						slot_wa = prev_q[SW-1:0];
						slot_wd = {prev_ent_q[EW-1:LW], snext_q};
					end
				end else begin
					slot_ra = cur_q[SW-1:0];
				end
			end
			ST_REL_CLR: begin
				slot_we = 1'b1;
				slot_wa = s_idx;
				slot_wd = {{(RW+REF_W){1'b0}}, SENT};
				pend_we = (pd_q < DW'(SLOT_COUNT));
				pend_wa = pd_q[SW-1:0];
				pend_wd = s_idx;
			end
			ST_RCL: begin
				// read and move pending entries, one per cycle with the read pipelined
				pend_ra = pd_dec[SW-1:0];
			end
			default: ;
		endcase
		// write side of the reclaim pipeline
		if (rcl_wr_q && fd_q < DW'(SLOT_COUNT)) begin
			free_we = 1'b1;
			free_wa = fd_q[SW-1:0];
			free_wd = pend_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rdata <= slot_mem[slot_ra];
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rdata <= head_mem[head_ra];
		if (free_we) free_mem[free_wa] <= free_wd;
		free_rdata <= free_mem[free_ra];
		if (pend_we) pend_mem[pend_wa] <= pend_wd;
		pend_rdata <= pend_mem[pend_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (q_pop) begin
					cmd_q <= q_data;
					res_q.slot_index    <= '0;
					res_q.needs_compose <= 1'b0;
					if (q_data.op == OP_ACQUIRE) res_q.outcome <= OUT_BLANK;
					else if (q_data.op == OP_RECLAIM && pool_en) res_q.outcome <= OUT_RECLAIMED;
					else res_q.outcome <= OUT_IGNORED;
				end
			end
			ST_ACQ_HD: begin
				cur_q   <= head_rdata;
				headv_q <= head_rdata;
				steps_q <= '0;
			end
			ST_ACQ_CHK: begin
				if (match) begin
					res_q.slot_index <= 9'(cur_q);
					res_q.outcome    <= OUT_SHARED;
				end else begin
					cur_q   <= rd_next;
					steps_q <= steps_inc;
				end
			end
			ST_ACQ_MISS: res_q.outcome <= OUT_EXHAUSTED;
			ST_ACQ_POP: begin
				if (pop_ok) begin
					res_q.slot_index    <= 9'(free_rdata);
					res_q.outcome       <= OUT_NEW;
					res_q.needs_compose <= 1'b1;
				end
			end
			ST_REL_CHK: begin
				snext_q <= rd_next;
				bkt_q   <= rel_bkt;
			end
			ST_REL_HD: begin
				cur_q   <= head_rdata;
				prev_q  <= SENT;
				steps_q <= '0;
			end
			ST_REL_WCHK: begin
				prev_q     <= cur_q;
				prev_ent_q <= slot_rdata;
				cur_q      <= rd_next;
				steps_q    <= steps_inc;
			end
			ST_REL_CLR: res_q.outcome <= OUT_RELEASED;
			default: ;
		endcase
		if (done_take) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			fd_q        <= DW'(SLOT_COUNT - 1);
			pd_q        <= '0;
			rcl_wr_q    <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
			if (st_q == ST_ACQ_MISS && fd_q != '0) fd_q <= fd_dec;
			else if (rcl_wr_q && fd_q < DW'(SLOT_COUNT)) fd_q <= fd_q + DW'(1);
			if (st_q == ST_REL_CLR && pd_q < DW'(SLOT_COUNT)) pd_q <= pd_q + DW'(1);
			else if (st_q == ST_RCL && pd_q != '0) pd_q <= pd_dec;
			rcl_wr_q <= (st_q == ST_RCL) && (pd_q != '0);
			// the last reclaim move lands in the cycle that leaves for idle
			if (finish) done_q <= 1'b1;
			else if (done_take) done_q <= 1'b0;
			if (done_take) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	assign clearing  = (st_q == ST_CLEAR) || out_load;
	assign res       = out_q;
	assign res_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== rtl/core/dedup_tile_slot_pool_top.sv =====
// back work: acquire ends at once if blank, else reads the bucket head, compares each link and,
// on a miss, reads the free stack and pops a new slot; release ends at once if ignored, else it
// reads the slot and, once unreferenced, walks the bucket chain to unlink it; reclaim ends at
// once if disabled, else moves each pending entry; one request in work at a time, the next taken
// once the last result has left; a 2-entry queue and the output register let requests and results
// move while it works; after reset a clearing pass over all slots and buckets holds s_tready low
`default_nettype none
module dedup_tile_slot_pool_top import dtsp_pkg::*; #(
	parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
	parameter int MAX_LAYERS   = DEF_MAX_LAYERS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// layer_count, layer_entry_0..3, release_slot
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// op
	input  wire logic [1:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// slot_index, needs_compose
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// outcome
	output logic [2:0]                  m_tuser,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data
);
	cmd_t f_cmd, q_cmd;
	logic f_push, q_full, q_empty, q_pop, clearing, pool_en_q;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pool_en_q <= 1'b1;
		else if (cfg_valid && cfg_ready) pool_en_q <= cfg_data;
	end

	dtsp_front #(
		.SLOT_COUNT(SLOT_COUNT), .BUCKET_COUNT(BUCKET_COUNT), .MAX_LAYERS(MAX_LAYERS)
	) u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.clearing(clearing), .q_full(q_full), .q_push(f_push), .cmd(f_cmd)
	);

	dtsp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_push), .wdata(f_cmd), .full(q_full),
		.pop(q_pop), .rdata(q_cmd), .empty(q_empty)
	);

	dtsp_back #(
		.SLOT_COUNT(SLOT_COUNT), .BUCKET_COUNT(BUCKET_COUNT), .MAX_LAYERS(MAX_LAYERS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_cmd), .q_empty(q_empty), .q_pop(q_pop),
		.pool_en(pool_en_q), .clearing(clearing), .res(res), .res_valid(m_tvalid),
		.res_ready(m_tready)
	);

	assign m_tdata = {6'd0, res.needs_compose, res.slot_index};
	assign m_tuser = res.outcome;
endmodule
`default_nettype wire

// ===== rtl/core/dtsp_checker.sv =====
// port-level checks of the tile slot pool results, bound to the top level
// depends on dtsp_pkg and dedup_tile_slot_pool_top_assert.svh
`default_nettype none
`include "dedup_tile_slot_pool_top_assert.svh"
module dtsp_checker import dtsp_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic [2:0]             m_tuser
);
	// only new and shared outcomes carry a slot
	logic slot_kept;
	assign slot_kept = (m_tuser == OUT_NEW) || (m_tuser == OUT_SHARED);

	`DTSP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`DTSP_ASSERT_IMP(a_compose_new, m_tvalid, m_tdata[9] == (m_tuser == OUT_NEW))
	`DTSP_ASSERT_IMP(a_zero_slot, m_tvalid && !slot_kept, m_tdata[8:0] == 9'd0)
	`DTSP_ASSERT_IMP(a_new_not_blank, m_tvalid && m_tuser == OUT_NEW, m_tdata[8:0] != 9'd0)
endmodule

bind dedup_tile_slot_pool_top dtsp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ===== sim/tb_dedup_tile_slot_pool_top.sv =====
// self-checking testbench for the deduplicating tile slot pool
// depends on dtsp_pkg and dedup_tile_slot_pool_top; a scoreboard class predicts results
`default_nettype none

module tb_dedup_tile_slot_pool_top;
	import dtsp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS   = DEF_SLOT_COUNT;
	localparam int BUCKETS = DEF_BUCKET_COUNT;
	localparam int LAYERS  = DEF_MAX_LAYERS;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [15:0] NO_LINK = 16'hFFFF;

	typedef struct {
		op_t         op;
		logic [2:0]  cnt;
		logic [15:0] ent [4];
		logic [15:0] rel;
	} req_t;

	typedef struct {
		logic [8:0] slot_index;
		outcome_t   outcome;
		logic       needs_compose;
	} exp_t;

	class pool_scoreboard;
		logic [15:0] recipe [SLOTS][4];
		logic [15:0] refcnt [SLOTS];
		logic [15:0] nxt [SLOTS];
		logic [15:0] head [BUCKETS];
		logic [15:0] free_stk [SLOTS];
		int          free_cnt;
		logic [15:0] pend_stk [SLOTS];
		int          pend_cnt;
		bit          enabled;
		exp_t        pending_results [$];
		int          errors;

		function void clear();
			for (int i = 0; i < SLOTS; i++) begin
				for (int j = 0; j < 4; j++) recipe[i][j] = 0;
				refcnt[i] = 0;
				nxt[i] = NO_LINK;
			end
			for (int i = 0; i < BUCKETS; i++) head[i] = NO_LINK;
			free_cnt = 0;
			for (int i = SLOTS - 1; i >= 1; i--) begin
				free_stk[free_cnt] = 16'(i);
				free_cnt++;
			end
			pend_cnt = 0;
			enabled = 1;
			errors = 0;
		endfunction

		function int recipe_len(int s);
			int n;
			n = 0;
			while (n < LAYERS && n < 4 && recipe[s][n] != 0) n++;
			return n;
		endfunction

		function int bucket_of(logic [15:0] r [4], int n);
			logic [31:0] h;
			h = n;
			for (int i = 0; i < n; i++) h = h * 33 + r[i];
			return int'(h & (BUCKETS - 1));
		endfunction

		function void note_request(req_t q);
			exp_t e;
			e.slot_index = 0;
			e.outcome = OUT_IGNORED;
			e.needs_compose = 0;
			if (q.op == OP_ACQUIRE) begin
				logic [15:0] nrm [4];
				int cnt, n, b, cur, s;
				bit found;
				nrm = '{0, 0, 0, 0};
				cnt = (q.cnt > 4) ? 4 : q.cnt;
				n = 0;
				found = 0;
				for (int i = 0; i < cnt; i++)
					if ((q.ent[i] & TILE_MASK) != 0 && n < LAYERS) begin
						nrm[n] = q.ent[i];
						n++;
					end
				if (n == 0) begin
					e.outcome = OUT_BLANK;
				end else begin
					b = bucket_of(nrm, n);
					cur = head[b];
					for (int k = 0; k < SLOTS && cur < SLOTS; k++) begin
						bit same;
						same = (recipe_len(cur) == n);
						for (int i = 0; i < n; i++) if (recipe[cur][i] != nrm[i]) same = 0;
						if (same) begin
							if (refcnt[cur] != REF_MAX) refcnt[cur]++;
							e.slot_index = 9'(cur);
							e.outcome = OUT_SHARED;
							found = 1;
							break;
						end
						cur = nxt[cur];
					end
					if (!found) begin
						if (free_cnt == 0) begin
							e.outcome = OUT_EXHAUSTED;
						end else begin
							free_cnt--;
							s = free_stk[free_cnt];
							recipe[s] = nrm;
							refcnt[s] = 1;
							nxt[s] = head[b];
							head[b] = 16'(s);
							e.slot_index = 9'(s);
							e.outcome = OUT_NEW;
							e.needs_compose = 1;
						end
					end
				end
			end else if (q.op == OP_RELEASE) begin
				int s;
				s = q.rel;
				if (s != 0 && s < SLOTS && refcnt[s] != 0) begin
					refcnt[s]--;
					if (refcnt[s] == 0) begin
						int b, cur, prev;
						b = bucket_of(recipe[s], recipe_len(s));
						cur = head[b];
						prev = -1;
						for (int k = 0; k < SLOTS && cur < SLOTS; k++) begin
							if (cur == s) begin
								if (prev < 0) head[b] = nxt[s];
								else nxt[prev] = nxt[s];
								break;
							end
							prev = cur;
							cur = nxt[cur];
						end
						nxt[s] = NO_LINK;
						recipe[s] = '{0, 0, 0, 0};
						pend_stk[pend_cnt] = 16'(s);
						pend_cnt++;
						e.outcome = OUT_RELEASED;
					end
				end
			end else if (q.op == OP_RECLAIM) begin
				if (enabled) begin
					while (pend_cnt != 0) begin
						pend_cnt--;
						free_stk[free_cnt] = pend_stk[pend_cnt];
						free_cnt++;
					end
					e.outcome = OUT_RECLAIMED;
				end
			end
			pending_results.push_back(e);
		endfunction

		function void check_result(logic [8:0] slot, logic [2:0] oc, logic comp);
			exp_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result: slot_index %0d outcome %0d", slot, oc);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (slot !== e.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", e.slot_index, slot);
				errors++;
			end
			if (oc !== e.outcome) begin
				$error("outcome: expected %0d, actual %0d", e.outcome, oc);
				errors++;
			end
			if (comp !== e.needs_compose) begin
				$error("needs_compose: expected %0d, actual %0d", e.needs_compose, comp);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;

	pool_scoreboard pool = new();
	int idle_cycles = 0;
	bit stall_on = 0;
	int stall_mode = 0;
	logic [15:0] live_slots [$];

	always #6 clk = ~clk;

	dedup_tile_slot_pool_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// result checking and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				pool.check_result(m_tdata[8:0], m_tuser, m_tdata[9]);
				if (m_tuser == OUT_NEW || m_tuser == OUT_SHARED)
					live_slots.push_back(16'(m_tdata[8:0]));
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_dedup_tile_slot_pool_top: errors");
			$finish;
		end
	end

	task automatic send(req_t q);
		s_tvalid <= 1'b1;
		s_tuser <= q.op;
		s_tdata <= {5'h0, q.rel, q.ent[3], q.ent[2], q.ent[1], q.ent[0], q.cnt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pool.note_request(q);
	endtask

	task automatic pause_gap();
		int g;
		g = $urandom_range(1, 6);
		s_tvalid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pool.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_enable(bit v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		pool.enabled = v;
	endtask

	function automatic req_t acquire_req(logic [2:0] cnt, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d);
		req_t q;
		q.op = OP_ACQUIRE;
		q.cnt = cnt;
		q.ent = '{a, b, c, d};
		q.rel = 16'($urandom);
		return q;
	endfunction

	function automatic req_t other_req(op_t op, logic [15:0] slot);
		req_t q;
		q.op = op;
		q.cnt = 3'($urandom);
		q.ent = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
		q.rel = slot;
		return q;
	endfunction

	// small tile ids keep recipes colliding so sharing and chains get exercised
	function automatic logic [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return {6'($urandom), 10'd0};
			default: return {4'($urandom_range(0, 1)), 2'($urandom), 10'($urandom_range(1, 6))};
		endcase
	endfunction

	function automatic req_t rand_req();
		int k;
		logic [15:0] s;
		k = $urandom_range(0, 99);
		if (k < 50)
			return acquire_req(3'($urandom_range(0, 7)), rand_entry(), rand_entry(),
				rand_entry(), rand_entry());
		if (k < 88) begin
			if (live_slots.size() != 0 && $urandom_range(0, 9) != 0) begin
				int i;
				i = $urandom_range(0, live_slots.size() - 1);
				s = live_slots[i];
				live_slots.delete(i);
			end else begin
				s = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 600));
			end
			return other_req(OP_RELEASE, s);
		end
		if (k < 97) return other_req(OP_RECLAIM, 16'($urandom));
		return other_req(OP_NONE, 16'($urandom));
	endfunction

	initial begin
		int burst;
		pool.clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		write_enable(1'b1);
		send(acquire_req(3'd0, 16'h0001, 16'h0002, 16'h0003, 16'h0004));
		send(acquire_req(3'd4, 16'hFC00, 16'h0400, 16'h0000, 16'hF000));
		send(acquire_req(3'd1, 16'hFFFF, 0, 0, 0));
		send(acquire_req(3'd1, 16'hFFFF, 0, 0, 0));
		send(acquire_req(3'd7, 16'h0001, 16'h0000, 16'h8002, 16'h0003));
		send(acquire_req(3'd4, 16'h0001, 16'h8002, 16'h0003, 16'h0004));
		send(acquire_req(3'd3, 16'h0001, 16'h8002, 16'h0003, 0));
		send(acquire_req(3'd2, 16'h03FF, 16'h0C01, 0, 0));
		send(other_req(OP_RELEASE, 16'd0));
		send(other_req(OP_RELEASE, 16'hFFFF));
		send(other_req(OP_RELEASE, 16'd511));
		send(other_req(OP_RELEASE, 16'd512));
		send(other_req(OP_RELEASE, 16'd510));
		send(other_req(OP_RELEASE, 16'd511));
		send(other_req(OP_RELEASE, 16'd511));
		send(other_req(OP_NONE, 16'd0));
		send(other_req(OP_RECLAIM, 16'd0));
		send(other_req(OP_RECLAIM, 16'd0));
		write_enable(1'b0);
		send(other_req(OP_RECLAIM, 16'd0));
		write_enable(1'b1);

		// exhaust the pool with distinct recipes, then a fill beyond
		for (int i = 0; i < 515; i++)
			send(acquire_req(3'd2, 16'(i + 1), 16'h0001, 0, 0));
		live_slots.delete();
		for (int i = 1; i < 512; i++) send(other_req(OP_RELEASE, 16'(i)));
		send(other_req(OP_RECLAIM, 16'd0));

		// random part with bursts and gaps
		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < 170; ) begin
				burst = $urandom_range(1, 12);
				for (int j = 0; j < burst; j++) begin
					send(rand_req());
					n++;
				end
				if ($urandom_range(0, 2) != 0) pause_gap();
			end
			write_enable(phase[0]);
		end
		write_enable(1'b1);

		drain();
		if (pool.errors == 0 && pool.pending_results.size() == 0)
			$display("tb_dedup_tile_slot_pool_top: clean");
		else
			$display("tb_dedup_tile_slot_pool_top: errors");
		$finish;
	end
endmodule

`default_nettype wire
